// File: design/rpa_pkg.sv
// Shared constants, codes and types of the refcounted pool allocator.
package rpa_pkg;

   localparam int POOL_SIZE   = 256;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W       = $clog2(POOL_SIZE);
   localparam int FC_W        = $clog2(POOL_SIZE + 1);
   localparam int CMD_W       = 2;
   localparam int SLOT_W      = 8;
   localparam int CNT_OUT_W   = 16;
   localparam int ST_W        = 2;
   localparam int DATA_IN_W   = 8;
   localparam int DATA_OUT_W  = 24;
   localparam int USER_OUT_W  = 3;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_REF   = 2'd1,
      CMD_REL   = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_ZERO  = 2'd2,
      ST_SAT   = 2'd3
   } status_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

endpackage

// File: design/rpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/rpa_ctrl.sv
// Command sequencer: accept, execute, and result word handshake.
module rpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output rpa_pkg::ctrl_cmd_type ctrl_cmd
);
   import rpa_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      ctrl_cmd.capture = 1'b0;
      ctrl_cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctrl_cmd.capture = 1'b1;
               state_in         = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               ctrl_cmd.execute = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: design/rpa_dp.sv
// Datapath: free stack, reference count table and result word register.
module rpa_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rpa_pkg::ctrl_cmd_type         ctrl_cmd,
   input  logic [rpa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [rpa_pkg::SLOT_W-1:0]    req_slot,
   output logic [rpa_pkg::SLOT_W-1:0]    rsp_index,
   output logic [rpa_pkg::CNT_OUT_W-1:0] rsp_count,
   output logic                          rsp_freed,
   output logic [rpa_pkg::ST_W-1:0]      rsp_status
);
   import rpa_pkg::*;

   cmd_type                cmd_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [FC_W-1:0]        fc_ff, fc_in;
   logic [FC_W-1:0]        lw_ff, lw_in;
   logic [POOL_SIZE-1:0]   valid_ff, valid_in;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic [CNT_OUT_W-1:0]   cnt_ff, cnt_in;
   logic                   freed_ff, freed_in;
   status_type             st_ff, st_in;

   logic                   stk_we;
   logic [IDX_W-1:0]       stk_waddr;
   logic [IDX_W-1:0]       stk_wdata;
   logic [IDX_W-1:0]       stk_rd;
   logic                   cnt_we;
   logic [IDX_W-1:0]       cnt_waddr;
   logic [COUNT_WIDTH-1:0] cnt_wdata;
   logic [COUNT_WIDTH-1:0] cnt_rd;

   logic [FC_W-1:0]        top_pos;
   logic [IDX_W-1:0]       top_val;
   logic [IDX_W-1:0]       slot_idx;
   logic                   in_range;
   logic [COUNT_WIDTH-1:0] cur;
   logic [COUNT_WIDTH-1:0] dec;

   rpa_ram #(.WIDTH(IDX_W), .DEPTH(POOL_SIZE)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (ctrl_cmd.capture),
      .rd_addr (top_pos[IDX_W-1:0]),
      .rd_data (stk_rd)
   );

   rpa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(POOL_SIZE)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (ctrl_cmd.capture),
      .rd_addr (IDX_W'(req_slot)),
      .rd_data (cnt_rd)
   );

   // stack entries below the low-water mark were never written; their reset value is computed here
   assign top_pos  = fc_ff - FC_W'(1);
   assign top_val  = (top_pos < lw_ff) ? (IDX_W'(POOL_SIZE - 1) - top_pos[IDX_W-1:0])
                                       : stk_rd;
   assign slot_idx = IDX_W'(slot_ff);
   assign in_range = (32'(slot_ff) < 32'(POOL_SIZE));
   assign cur      = (in_range && valid_ff[slot_idx]) ? cnt_rd : '0;
   assign dec      = cur - COUNT_WIDTH'(1);

   always_comb begin
      fc_in     = fc_ff;
      lw_in     = lw_ff;
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      freed_in  = freed_ff;
      st_in     = st_ff;
      stk_we    = 1'b0;
      stk_waddr = fc_ff[IDX_W-1:0];
      stk_wdata = slot_idx;
      cnt_we    = 1'b0;
      cnt_waddr = slot_idx;
      cnt_wdata = cur;
      if (ctrl_cmd.execute) begin
         idx_in   = slot_ff;
         cnt_in   = CNT_OUT_W'(cur);
         freed_in = 1'b0;
         st_in    = ST_OK;
         case (cmd_ff)
            CMD_ALLOC: begin
               if (fc_ff == '0) begin
                  idx_in = '0;
                  cnt_in = '0;
                  st_in  = ST_EMPTY;
               end else begin
                  fc_in              = top_pos;
                  lw_in              = (top_pos < lw_ff) ? top_pos : lw_ff;
                  cnt_we             = 1'b1;
                  cnt_waddr          = top_val;
                  cnt_wdata          = COUNT_WIDTH'(1);
                  valid_in[top_val]  = 1'b1;
                  idx_in             = SLOT_W'(top_val);
                  cnt_in             = CNT_OUT_W'(1);
               end
            end
            CMD_NOP: ;
            default: begin
               if (cur == '0) begin
                  cnt_in = '0;
                  st_in  = ST_ZERO;
               end else if (cmd_ff == CMD_REF) begin
                  if (cur == COUNT_MAX) begin
                     st_in = ST_SAT;
                  end else begin
                     cnt_we    = 1'b1;
                     cnt_wdata = cur + COUNT_WIDTH'(1);
                     cnt_in    = CNT_OUT_W'(cur + COUNT_WIDTH'(1));
                  end
               end else begin
                  cnt_we    = 1'b1;
                  cnt_wdata = dec;
                  cnt_in    = CNT_OUT_W'(dec);
                  if (dec == '0) begin
                     freed_in = 1'b1;
                     if (32'(fc_ff) < 32'(POOL_SIZE)) begin
                        stk_we = 1'b1;
                        fc_in  = fc_ff + FC_W'(1);
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff    <= FC_W'(POOL_SIZE);
         lw_ff    <= FC_W'(POOL_SIZE);
         valid_ff <= '0;
      end else begin
         fc_ff    <= fc_in;
         lw_ff    <= lw_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         cmd_ff  <= cmd_type'(req_cmd);
         slot_ff <= req_slot;
      end
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      freed_ff <= freed_in;
      st_ff    <= st_in;
   end

   assign rsp_index  = idx_ff;
   assign rsp_count  = cnt_ff;
   assign rsp_freed  = freed_ff;
   assign rsp_status = st_ff;

endmodule

// File: design/refcounted_pool_allocator.sv
// Top level of the refcounted pool allocator: free stack plus reference counts.
// A word accepted in the idle state is captured with the registered reads of the
// stack and count RAMs; its result word is registered in the execute state, which
// waits while an earlier result word is held. No new word is accepted until then.
// Reset: synchronous; free stack full with slot 0 on top, all counts zero,
// no clearing pass (low-water mark and valid bits stand in for it).
module refcounted_pool_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rpa_pkg::DATA_IN_W-1:0]     req_tdata,  // slot_index
   input  logic [rpa_pkg::CMD_W-1:0]         req_tuser,  // cmd
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rpa_pkg::DATA_OUT_W-1:0]    rsp_tdata,  // result_index, count_after
   output logic [rpa_pkg::USER_OUT_W-1:0]    rsp_tuser   // slot_freed, status
);
   import rpa_pkg::*;

   ctrl_cmd_type          ctrl_cmd;
   logic [SLOT_W-1:0]     rsp_index;
   logic [CNT_OUT_W-1:0]  rsp_count;
   logic                  rsp_freed;
   logic [ST_W-1:0]       rsp_status;

   rpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl_cmd   (ctrl_cmd)
   );

   rpa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl_cmd   (ctrl_cmd),
      .req_cmd    (req_tuser),
      .req_slot   (req_tdata[SLOT_W-1:0]),
      .rsp_index  (rsp_index),
      .rsp_count  (rsp_count),
      .rsp_freed  (rsp_freed),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {rsp_count, rsp_index};
   assign rsp_tuser = {rsp_status, rsp_freed};

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word accepted while one is in flight");

   a_freed_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_freed) |-> (rsp_status == ST_OK && rsp_count == '0))
      else $error("freed slot with nonzero count or error status");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_SAT) |-> (rsp_count == CNT_OUT_W'(COUNT_MAX)))
      else $error("saturated status without count at limit");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_EMPTY) |-> (rsp_index == '0 && !rsp_freed))
      else $error("empty pool result carries an index");

endmodule

// File: sim/rpa_checker.sv
// Checker for the refcounted pool allocator: tracks the pool and compares every result word.
`timescale 1ns / 100ps

module rpa_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [rpa_pkg::DATA_IN_W-1:0]  req_tdata,   // slot_index
   input  logic [rpa_pkg::CMD_W-1:0]      req_tuser,   // cmd
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [rpa_pkg::DATA_OUT_W-1:0] rsp_tdata,   // result_index, count_after
   input  logic [rpa_pkg::USER_OUT_W-1:0] rsp_tuser,   // slot_freed, status
   output int                             pending_results,
   output int                             mismatch_count
);
   import rpa_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]       index;
      logic [COUNT_WIDTH-1:0] count;
      logic                   freed;
      status_type             status;
   } pool_result_type;

   logic [IDX_W-1:0]       free_stack [POOL_SIZE];
   logic [FC_W-1:0]        free_level;
   logic [COUNT_WIDTH-1:0] ref_count [POOL_SIZE];
   pool_result_type        expected_q [$];
   int                     mismatches = 0;
   int                     words_checked = 0;

   task automatic clear_pool();
      for (int k = 0; k < POOL_SIZE; k++) begin
         free_stack[k] = IDX_W'(POOL_SIZE - 1 - k);
         ref_count[k]  = '0;
      end
      free_level = FC_W'(POOL_SIZE);
   endtask

   task automatic apply_command(input cmd_type c, input logic [SLOT_W-1:0] s,
                                output pool_result_type r);
      logic [COUNT_WIDTH-1:0] cur;
      cur = ref_count[s];
      r = '{index: s, count: cur, freed: 1'b0, status: ST_OK};
      case (c)
         CMD_ALLOC: begin
            if (free_level == 0) begin
               r = '{index: '0, count: '0, freed: 1'b0, status: ST_EMPTY};
            end else begin
               free_level = free_level - 1'b1;
               r.index = free_stack[free_level];
               ref_count[r.index] = COUNT_WIDTH'(1);
               r.count = COUNT_WIDTH'(1);
            end
         end
         CMD_REF, CMD_REL: begin
            if (cur == 0) begin
               r.status = ST_ZERO;
            end else if (c == CMD_REF) begin
               if (cur == COUNT_MAX) begin
                  r.status = ST_SAT;
               end else begin
                  ref_count[s] = cur + 1'b1;
                  r.count = cur + 1'b1;
               end
            end else begin
               ref_count[s] = cur - 1'b1;
               r.count = cur - 1'b1;
               if (cur == 1) begin
                  r.freed = 1'b1;
                  // guard: a full stack drops the push
                  if (free_level < POOL_SIZE) begin
                     free_stack[free_level] = s;
                     free_level = free_level + 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: word %0d %s mismatch: expected %0d, got %0d",
                     $realtime, words_checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      pool_result_type want, got;
      if (reset) begin
         clear_pool();
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.index  = rsp_tdata[IDX_W-1:0];
            got.count  = rsp_tdata[IDX_W +: CNT_OUT_W];
            got.freed  = rsp_tuser[0];
            got.status = status_type'(rsp_tuser[ST_W:1]);
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result word with nothing outstanding: index %0d count %0d",
                           $realtime, got.index, got.count);
            end else begin
               want = expected_q.pop_front();
               check_field("result_index", want.index, got.index);
               check_field("count_after", want.count, got.count);
               check_field("slot_freed", want.freed, got.freed);
               check_field("status", want.status, got.status);
            end
            words_checked++;
         end
         if (req_tvalid && req_tready) begin
            apply_command(cmd_type'(req_tuser), req_tdata[SLOT_W-1:0], want);
            expected_q.push_back(want);
         end
      end
      pending_results <= expected_q.size();
      mismatch_count  <= mismatches;
   end

endmodule

// File: sim/tb_refcounted_pool_allocator.sv
// Testbench top for the refcounted pool allocator: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps

module tb_refcounted_pool_allocator;
   import rpa_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int ROUNDS      = 8;
   localparam int ROUND_WORDS = 90;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_IN_W-1:0]  req_tdata = '0;   // slot_index
   logic [CMD_W-1:0]      req_tuser = '0;   // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_OUT_W-1:0] rsp_tdata;        // result_index, count_after
   logic [USER_OUT_W-1:0] rsp_tuser;        // slot_freed, status

   int pending_results;
   int mismatch_count;
   bit quiet = 1'b0;
   bit held [POOL_SIZE];
   int sent_per_cmd [4];
   int status_seen [4];
   int hold_left = 0;
   int idle_cycles = 0;

   refcounted_pool_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rpa_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (quiet) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 70);
         hold_left  <= idle_length();
      end
   end

   // live-slot view taken from the result words, used to aim references and releases
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         status_seen[rsp_tuser[ST_W:1]] <= status_seen[rsp_tuser[ST_W:1]] + 1;
         if (rsp_tuser[0])
            held[rsp_tdata[IDX_W-1:0]] <= 1'b0;
         else if ((rsp_tuser[ST_W:1] == ST_OK || rsp_tuser[ST_W:1] == ST_SAT)
                  && rsp_tdata[IDX_W +: CNT_OUT_W] != 0)
            held[rsp_tdata[IDX_W-1:0]] <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(input cmd_type c, input logic [SLOT_W-1:0] s);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tuser  <= c;
      sent_per_cmd[c]++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   function automatic int pick_held();
      int live [$];
      for (int k = 0; k < POOL_SIZE; k++)
         if (held[k]) live.push_back(k);
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
   endfunction

   task automatic random_word(input int alloc_pct, input int release_pct);
      int r;
      int slot;
      r    = $urandom_range(0, 99);
      slot = pick_held();
      if (r < alloc_pct || (r < 94 && slot < 0))
         send_word(CMD_ALLOC, SLOT_W'($urandom_range(0, 255)));
      else if (r < 94)
         send_word(($urandom_range(0, 99) < release_pct) ? CMD_REL : CMD_REF,
                   SLOT_W'(slot));
      else if (r < 98)
         send_word($urandom_range(0, 1) ? CMD_REL : CMD_REF,
                   SLOT_W'($urandom_range(0, 255)));
      else
         send_word(CMD_NOP, SLOT_W'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: basic flow, zero-count errors, no-op, slot field ignored on allocate
      send_word(CMD_ALLOC, 8'h00);
      send_word(CMD_ALLOC, 8'h00);
      send_word(CMD_REF, 8'h00);
      send_word(CMD_REF, 8'h00);
      send_word(CMD_REL, 8'h00);
      send_word(CMD_REL, 8'h01);
      send_word(CMD_REL, 8'h01);
      send_word(CMD_REF, 8'h01);
      send_word(CMD_REF, 8'hFF);
      send_word(CMD_REL, 8'hFF);
      send_word(CMD_NOP, 8'h00);
      send_word(CMD_NOP, 8'hFF);
      send_word(CMD_NOP, 8'hAA);
      send_word(CMD_REF, 8'h55);
      send_word(CMD_REL, 8'hAA);
      send_word(CMD_ALLOC, 8'h00);
      send_word(CMD_ALLOC, 8'h00);
      send_word(CMD_REL, 8'h02);
      send_word(CMD_ALLOC, 8'hFF);
      send_word(CMD_REL, 8'h02);

      // exhaust the pool, then hand every slot but 0 back
      drain();
      repeat (POOL_SIZE + 3) send_word(CMD_ALLOC, SLOT_W'($urandom_range(0, 255)));
      drain();
      for (int k = 1; k < POOL_SIZE; k++)
         if (held[k]) send_word(CMD_REL, SLOT_W'(k));

      for (int round = 0; round < ROUNDS; round++) begin
         quiet = (round == 3);
         case (round % 3)
            0:       repeat (ROUND_WORDS) random_word(55, 30);
            1:       repeat (ROUND_WORDS) random_word(10, 70);
            default: repeat (ROUND_WORDS) random_word(30, 50);
         endcase
         if (round == 4) drain();
      end
      quiet = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      $display("covered %0d allocate, %0d reference, %0d release and %0d no-op words,",
               sent_per_cmd[CMD_ALLOC], sent_per_cmd[CMD_REF], sent_per_cmd[CMD_REL],
               sent_per_cmd[CMD_NOP]);
      $display("pool run dry and refilled (%0d ok, %0d empty, %0d zero, %0d saturated)",
               status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_ZERO],
               status_seen[ST_SAT]);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: sim.f
design/rpa_pkg.sv
design/rpa_ram.sv
design/rpa_ctrl.sv
design/rpa_dp.sv
design/refcounted_pool_allocator.sv
sim/rpa_checker.sv
sim/tb_refcounted_pool_allocator.sv
